// ===== hdl/pva_pkg.sv =====
// shared types and constants of the polyphonic voice allocator
// event codes, frequency table, payload structs and controller/datapath links
// no dependencies
package pva_pkg;

    // event codes
    localparam logic [3:0] EVT_PRESS   = 4'd9;
    localparam logic [3:0] EVT_RELEASE = 4'd8;

    // register map: word index of each register
    localparam int          APB_ADDR_W        = 3;
    localparam int          APB_DATA_W        = 32;
    localparam logic [0:0]  REG_DUTY_FRACTION = 1'b0;
    localparam logic [7:0]  DUTY_RESET        = 8'd64;

    // tone frequency in whole hertz, never below 8 and never above FREQ_MAX
    localparam int          F_W      = 14;
    localparam int          DEN_W    = F_W + 9;
    localparam int          FREQ_MAX = 12543;

    localparam logic [F_W-1:0] FREQ_TABLE [128] = '{
        14'd8,     14'd8,     14'd9,     14'd9,     14'd10,    14'd10,
        14'd11,    14'd12,    14'd12,    14'd13,    14'd14,    14'd15,
        14'd16,    14'd17,    14'd18,    14'd19,    14'd20,    14'd21,
        14'd23,    14'd24,    14'd25,    14'd27,    14'd29,    14'd30,
        14'd32,    14'd34,    14'd36,    14'd38,    14'd41,    14'd43,
        14'd46,    14'd48,    14'd51,    14'd55,    14'd58,    14'd61,
        14'd65,    14'd69,    14'd73,    14'd77,    14'd82,    14'd87,
        14'd92,    14'd97,    14'd103,   14'd110,   14'd116,   14'd123,
        14'd130,   14'd138,   14'd146,   14'd155,   14'd164,   14'd174,
        14'd184,   14'd195,   14'd207,   14'd220,   14'd233,   14'd246,
        14'd261,   14'd277,   14'd293,   14'd311,   14'd329,   14'd349,
        14'd369,   14'd391,   14'd415,   14'd440,   14'd466,   14'd493,
        14'd523,   14'd554,   14'd587,   14'd622,   14'd659,   14'd698,
        14'd739,   14'd783,   14'd830,   14'd880,   14'd932,   14'd987,
        14'd1046,  14'd1108,  14'd1174,  14'd1244,  14'd1318,  14'd1396,
        14'd1479,  14'd1567,  14'd1661,  14'd1760,  14'd1864,  14'd1975,
        14'd2093,  14'd2217,  14'd2349,  14'd2489,  14'd2637,  14'd2793,
        14'd2959,  14'd3135,  14'd3322,  14'd3520,  14'd3729,  14'd3951,
        14'd4186,  14'd4434,  14'd4698,  14'd4978,  14'd5274,  14'd5587,
        14'd5919,  14'd6271,  14'd6644,  14'd7040,  14'd7458,  14'd7902,
        14'd8372,  14'd8869,  14'd9397,  14'd9956,  14'd10548, 14'd11175,
        14'd11839, 14'd12543
    };

    typedef struct packed {
        logic [3:0] req_type;
        logic [6:0] note_number;
    } pva_in_t;

    typedef struct packed {
        logic        applied;
        logic [2:0]  voice_index;
        logic        write_period;
        logic [15:0] tone_period;
        logic [15:0] high_time;
        logic        led_on;
    } pva_out_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic prep;
        logic start_div;
        logic commit;
    } pva_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic on_ok;
        logic div_done;
        logic out_free;
    } pva_sts_t;

endpackage

// ===== hdl/pva_divider.sv =====
// iterative restoring divider, one quotient bit per cycle
// no package dependencies
module pva_divider #(
    parameter int NUM_W = 28,
    parameter int DW    = 23
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DW-1:0]    den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DW:0]      rem_sh;
    logic [DW:0]      diff;

    always_comb begin
        rem_sh   = {rem_reg, q_reg[NUM_W-1]};
        diff     = rem_sh - {1'b0, den_reg};
        if (!diff[DW]) begin
            rem_next = diff[DW-1:0];
            q_next   = {q_reg[NUM_W-2:0], 1'b1};
        end else begin
            rem_next = rem_sh[DW-1:0];
            q_next   = {q_reg[NUM_W-2:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (run_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // operands
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (run_reg) begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== hdl/pva_datapath.sv =====
// voice table, active count, tone arithmetic and result register
// depends on pva_pkg and pva_divider
module pva_datapath #(
    parameter int NUM_VOICES    = 8,
    parameter int PWM_TICK_RATE = 500000
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pva_pkg::pva_cmd_t cmd,
    output pva_pkg::pva_sts_t sts,
    input  pva_pkg::pva_in_t  s_data,
    input  logic [7:0]        duty,
    output logic              m_valid,
    input  logic              m_ready,
    output pva_pkg::pva_out_t m_data
);

    localparam int VOICE_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CNT_W   = $clog2(NUM_VOICES + 1);
    localparam longint unsigned TWO_R   = 64'd2 * 64'(PWM_TICK_RATE);
    localparam longint unsigned MAX_NUM = 64'd255 * TWO_R + 64'd256 * 64'(pva_pkg::FREQ_MAX);
    localparam int NUM_W   = $clog2(MAX_NUM + 64'd1);

    // item under work
    logic [3:0] type_reg;
    logic [6:0] note_reg;

    // voice state
    logic [NUM_VOICES-1:0] busy_reg, busy_next;
    logic [6:0]            note_mem [NUM_VOICES];
    logic [CNT_W-1:0]      active_count_reg, active_count_next;
    logic                  led_reg, led_next;

    // divider operands
    logic [NUM_W-1:0]          pnum_reg, hnum_reg;
    logic [pva_pkg::DEN_W-1:0] pden_reg, hden_reg;
    logic [NUM_W-1:0]          pquot, hquot;
    logic                      pdone, hdone;
    logic [pva_pkg::F_W-1:0]   freq;

    // search results
    logic               free_found, hit_found;
    logic [VOICE_W-1:0] free_idx, hit_idx;
    logic               take, release_v;
    logic [CNT_W-1:0]   cnt_inc, cnt_dec;

    logic              out_valid_reg;
    pva_pkg::pva_out_t out_reg, out_next;

    // lowest-numbered free voice and lowest-numbered voice holding the note
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        hit_found  = 1'b0;
        hit_idx    = '0;
        for (int v = NUM_VOICES - 1; v >= 0; v--) begin
            if (!busy_reg[v]) begin
                free_found = 1'b1;
                free_idx   = VOICE_W'(v);
            end
            if (busy_reg[v] && note_mem[v] == note_reg) begin
                hit_found = 1'b1;
                hit_idx   = VOICE_W'(v);
            end
        end
    end

    assign take      = (type_reg == pva_pkg::EVT_PRESS) && free_found;
    assign release_v = (type_reg == pva_pkg::EVT_RELEASE) && hit_found;
    assign cnt_inc   = active_count_reg + CNT_W'(1);
    assign cnt_dec   = (active_count_reg != '0) ? active_count_reg - CNT_W'(1) : '0;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            type_reg <= s_data.req_type;
            note_reg <= s_data.note_number;
        end
    end

    // operands: period = (2r + f) / 2f, high = (2dr + 256f) / 512f
    assign freq = pva_pkg::FREQ_TABLE[note_reg];

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            pnum_reg <= NUM_W'(TWO_R) + NUM_W'(freq);
            pden_reg <= pva_pkg::DEN_W'({freq, 1'b0});
            hnum_reg <= NUM_W'(NUM_W'(duty) * NUM_W'(TWO_R)) + NUM_W'({freq, 8'd0});
            hden_reg <= {freq, 9'd0};
        end
    end

    pva_divider #(.NUM_W(NUM_W), .DW(pva_pkg::DEN_W)) u_period_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start_div),
        .num     (pnum_reg),
        .den     (pden_reg),
        .done    (pdone),
        .quot    (pquot)
    );

    pva_divider #(.NUM_W(NUM_W), .DW(pva_pkg::DEN_W)) u_high_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start_div),
        .num     (hnum_reg),
        .den     (hden_reg),
        .done    (hdone),
        .quot    (hquot)
    );

    // state update and result
    always_comb begin
        busy_next         = busy_reg;
        active_count_next = active_count_reg;
        led_next          = led_reg;
        out_next          = '0;
        if (take) begin
            busy_next[free_idx]  = 1'b1;
            active_count_next    = cnt_inc;
            if (int'(cnt_inc) >= 2) begin
                led_next = 1'b1;
            end
            out_next.applied      = 1'b1;
            out_next.voice_index  = 3'(free_idx);
            out_next.write_period = 1'b1;
            out_next.tone_period  = (|pquot[NUM_W-1:16]) ? 16'hFFFF : pquot[15:0];
            out_next.high_time    = (|hquot[NUM_W-1:16]) ? 16'hFFFF : hquot[15:0];
        end else if (release_v) begin
            busy_next[hit_idx]   = 1'b0;
            active_count_next    = cnt_dec;
            if (int'(cnt_dec) <= 1) begin
                led_next = 1'b0;
            end
            out_next.applied     = 1'b1;
            out_next.voice_index = 3'(hit_idx);
        end
        out_next.led_on = led_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg         <= '0;
            active_count_reg <= '0;
            led_reg          <= 1'b0;
        end else if (cmd.commit) begin
            busy_reg         <= busy_next;
            active_count_reg <= active_count_next;
            led_reg          <= led_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && take) begin
            note_mem[free_idx] <= note_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_data       = out_reg;
    assign sts.on_ok    = take;
    assign sts.div_done = pdone & hdone;
    assign sts.out_free = !out_valid_reg || m_ready;

    a_count_matches_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(active_count_reg) == $countones(busy_reg))
        else $error("active count differs from busy voices");

    a_led_tracks_count: assert property (@(posedge aclk) disable iff (!aresetn)
        led_reg == (int'(active_count_reg) >= 2))
        else $error("led state differs from active count");

    a_commit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!out_valid_reg || m_ready))
        else $error("result overwritten before transaction");

    a_period_only_applied: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.write_period |-> out_reg.applied)
        else $error("period written without an applied voice");

endmodule

// ===== hdl/pva_ctrl.sv =====
// sequencer for the voice allocator: capture, operand set-up, divide, commit
// depends on pva_pkg
module pva_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pva_pkg::pva_sts_t sts,
    output pva_pkg::pva_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_DIVIDE = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (sts.on_ok) begin
                    cmd.prep   = 1'b1;
                    state_next = ST_START;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_START: begin
                cmd.start_div = 1'b1;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (sts.div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

// ===== hdl/polyphonic_voice_allocator.sv =====
// polyphonic voice allocator, first free voice; depends on pva_pkg, pva_ctrl, pva_datapath
// note on: capture, operand set-up, bit-serial divide, commit once the result slot is free;
//   NUM_W = bits of 510 * PWM_TICK_RATE + 256 * 12543 (28 by default), the divider width
// note off and ignored codes: capture, decide, commit once the result slot is free
// one event in flight; next taken the cycle after commit
// synchronous active-low reset frees every voice, clears count and led, duty back to 64
module polyphonic_voice_allocator #(
    parameter int NUM_VOICES    = 8,
    parameter int PWM_TICK_RATE = 500000
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // event input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  pva_pkg::pva_in_t                 s_data,
    // result output
    output logic                             m_valid,
    input  logic                             m_ready,
    output pva_pkg::pva_out_t                m_data,
    // register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pva_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pva_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pva_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic [7:0]        duty_reg;
    logic              reg_hit;
    pva_pkg::pva_cmd_t cmd;
    pva_pkg::pva_sts_t sts;

    // register decode: word index sits above the byte offset
    assign reg_hit = (paddr[pva_pkg::APB_ADDR_W-1:2] == pva_pkg::REG_DUTY_FRACTION);

    // duty written on the access phase of a write transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg <= pva_pkg::DUTY_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            duty_reg <= pwdata[7:0];
        end
    end

    // no wait states
    assign pready = 1'b1;
    assign prdata = reg_hit ? {{(pva_pkg::APB_DATA_W - 8){1'b0}}, duty_reg} : '0;

    // sequencer
    pva_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // voice table, dividers and result register
    pva_datapath #(
        .NUM_VOICES    (NUM_VOICES),
        .PWM_TICK_RATE (PWM_TICK_RATE)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_data  (s_data),
        .duty    (duty_reg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
